FILE: src/smkf_pkg.sv
// Shared types, constants and saturating Q32.32 helpers for the scalar
// measurement Kalman filter. No dependencies.
package smkf_pkg;

    localparam int N  = 4;                        // state elements
    localparam int IW = (N > 1) ? $clog2(N) : 1;  // element / cell index width
    localparam int DW = 64;

    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [62:0] R_RESET = 63'h0000_0001_0000_0000;   // 1.0

    // input function codes
    localparam logic [2:0] FN_LOAD_A = 3'd0;
    localparam logic [2:0] FN_LOAD_Q = 3'd1;
    localparam logic [2:0] FN_LOAD_C = 3'd2;
    localparam logic [2:0] FN_LOAD_X = 3'd3;
    localparam logic [2:0] FN_LOAD_P = 3'd4;
    localparam logic [2:0] FN_LOAD_U = 3'd5;
    localparam logic [2:0] FN_STEP   = 3'd6;

    // multiplier operand A source (local to the cell)
    typedef enum logic [2:0] {
        A_A, A_M, A_PP, A_PC, A_XP, A_K
    } t_asel;

    // multiplier operand B source
    typedef enum logic {
        B_BCAST, B_C
    } t_bsel;

    // accumulator write-back target
    typedef enum logic [2:0] {
        WB_NONE, WB_XP_U, WB_M, WB_PP, WB_PC, WB_K, WB_X, WB_P
    } t_wb;

    // read port source
    typedef enum logic [2:0] {
        RD_A, RD_P, RD_C, RD_X, RD_PP
    } t_src;

    typedef struct packed {
        logic                 ld_en;
        logic [2:0]           ld_func;
        logic [1:0]           ld_row;
        logic [1:0]           ld_col;
        logic signed [DW-1:0] ld_val;
        logic                 go;
        logic                 clr;
        t_asel                asel;
        t_bsel                bsel;
        logic [IW-1:0]        q;
        logic signed [DW-1:0] bcast;
        t_wb                  wb;
        logic [IW-1:0]        j;
        t_src                 rd_src;
        logic [IW-1:0]        rd_idx;
    } t_cmd;

    function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [DW-1:0] s;
        s = a + b;
        if (a[DW-1] == b[DW-1] && s[DW-1] != a[DW-1]) begin
            s = a[DW-1] ? SMIN : SMAX;
        end
        return s;
    endfunction

    function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [DW-1:0] s;
        s = a - b;
        if (a[DW-1] != b[DW-1] && s[DW-1] != a[DW-1]) begin
            s = a[DW-1] ? SMIN : SMAX;
        end
        return s;
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
        return a[DW-1] ? DW'(-a) : DW'(a);
    endfunction

    // apply sign to a 65-bit magnitude, saturating
    function automatic logic signed [DW-1:0] sat_mag(input logic neg,
                                                     input logic [DW:0] m);
        logic signed [DW-1:0] r;
        if (neg) begin
            if (m >= {2'b01, {(DW-1){1'b0}}}) r = SMIN;
            else                             r = -$signed(m[DW-1:0]);
        end else begin
            if (m > {2'b00, {(DW-1){1'b1}}}) r = SMAX;
            else                             r = $signed(m[DW-1:0]);
        end
        return r;
    endfunction

endpackage

FILE: src/smkf_recip.sv
// Iterative reciprocal 2^64 / |S| in Q32.32, one quotient bit per cycle.
// Depends on smkf_pkg.
module smkf_recip (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [smkf_pkg::DW-1:0] i_s,
    output logic                          o_done,
    output logic signed [smkf_pkg::DW-1:0] o_rec
);
    logic                        r_busy;
    logic                        r_done;
    logic [6:0]                  r_cnt;
    logic [smkf_pkg::DW:0]       r_rem;
    logic [smkf_pkg::DW:0]       r_quo;
    logic [smkf_pkg::DW-1:0]     r_m;
    logic                        r_neg;
    logic [smkf_pkg::DW:0]       w_t;
    logic                        w_ge;

    // dividend is a single one followed by 64 zeros
    assign w_t  = {r_rem[smkf_pkg::DW-1:0], (r_cnt == 7'd0)};
    assign w_ge = (w_t >= {1'b0, r_m});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // pulse after the final quotient bit
            r_done <= r_busy && !i_start && (r_cnt == 7'd64);
            if (i_start) begin
                r_m    <= smkf_pkg::mag(i_s);
                r_neg  <= i_s[smkf_pkg::DW-1];
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_t - {1'b0, r_m} : w_t;
                r_quo <= {r_quo[smkf_pkg::DW-1:0], w_ge};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd64) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    // zero variance gives zero gain
    assign o_rec  = (r_m == '0) ? '0 : smkf_pkg::sat_mag(r_neg, r_quo);

endmodule

FILE: src/smkf_cell.sv
// One filter cell: holds row i of A, Q, P and scratch matrices plus element i
// of x, C, u; multi-cycle Q32.32 MAC and a saturating sum chain. Uses smkf_pkg.
module smkf_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [smkf_pkg::IW-1:0]        i_idx,
    input  smkf_pkg::t_cmd                 i_cmd,
    input  logic signed [smkf_pkg::DW-1:0] i_chain,
    output logic signed [smkf_pkg::DW-1:0] o_chain,
    output logic signed [smkf_pkg::DW-1:0] o_rd
);
    localparam int N  = smkf_pkg::N;
    localparam int DW = smkf_pkg::DW;

    logic signed [DW-1:0] r_a  [N];
    logic signed [DW-1:0] r_q  [N];
    logic signed [DW-1:0] r_p  [N];
    logic signed [DW-1:0] r_m  [N];
    logic signed [DW-1:0] r_pp [N];
    logic signed [DW-1:0] r_x, r_c, r_u, r_xp, r_pc, r_k, r_acc, r_chain;

    logic [DW-1:0]   r_xm, r_ym;
    logic            r_neg, r_clr;
    logic [2:0]      r_ph;           // 0 idle, 1..4 partial products, 5 finish
    logic [2*DW-1:0] r_sum;

    logic signed [DW-1:0] w_opa, w_opb, w_prod;
    logic [31:0]          w_xa, w_ya;
    logic [63:0]          w_pp;
    logic [2*DW-1:0]      w_add;
    logic                 w_hit, w_mat;
    logic [smkf_pkg::IW-1:0] w_col;

    assign w_hit = (32'(i_cmd.ld_row) == 32'(i_idx));
    assign w_mat = (i_cmd.ld_func == smkf_pkg::FN_LOAD_A) ||
                   (i_cmd.ld_func == smkf_pkg::FN_LOAD_Q) ||
                   (i_cmd.ld_func == smkf_pkg::FN_LOAD_P);
    assign w_col = smkf_pkg::IW'(i_cmd.ld_col);

    always_comb begin
        case (i_cmd.asel)
            smkf_pkg::A_A:  w_opa = r_a[i_cmd.q];
            smkf_pkg::A_M:  w_opa = r_m[i_cmd.q];
            smkf_pkg::A_PP: w_opa = r_pp[i_cmd.q];
            smkf_pkg::A_PC: w_opa = r_pc;
            smkf_pkg::A_XP: w_opa = r_xp;
            default:        w_opa = r_k;
        endcase
        w_opb = (i_cmd.bsel == smkf_pkg::B_C) ? r_c : i_cmd.bcast;
    end

    always_comb begin
        case (i_cmd.rd_src)
            smkf_pkg::RD_A:  o_rd = r_a[i_cmd.rd_idx];
            smkf_pkg::RD_P:  o_rd = r_p[i_cmd.rd_idx];
            smkf_pkg::RD_C:  o_rd = r_c;
            smkf_pkg::RD_X:  o_rd = r_x;
            default:         o_rd = r_pp[i_cmd.rd_idx];
        endcase
    end

    // partial products of the magnitudes, one 32x32 per cycle
    always_comb begin
        w_xa = (r_ph == 3'd3 || r_ph == 3'd4) ? r_xm[63:32] : r_xm[31:0];
        w_ya = (r_ph == 3'd2 || r_ph == 3'd4) ? r_ym[63:32] : r_ym[31:0];
        w_pp = w_xa * w_ya;
        case (r_ph)
            3'd1:    w_add = {64'b0, w_pp};
            3'd4:    w_add = {w_pp, 64'b0};
            default: w_add = {32'b0, w_pp, 32'b0};
        endcase
        if (r_sum[127:96] != 32'b0) begin
            w_prod = r_neg ? smkf_pkg::SMIN : smkf_pkg::SMAX;
        end else begin
            w_prod = smkf_pkg::sat_mag(r_neg, {1'b0, r_sum[95:32]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= '0;
            r_u  <= '0;
        end else begin
            if (i_cmd.ld_en && w_hit && (!w_mat || 32'(i_cmd.ld_col) < N)) begin
                case (i_cmd.ld_func)
                    smkf_pkg::FN_LOAD_A: r_a[w_col] <= i_cmd.ld_val;
                    smkf_pkg::FN_LOAD_Q: r_q[w_col] <= i_cmd.ld_val;
                    smkf_pkg::FN_LOAD_C: r_c        <= i_cmd.ld_val;
                    smkf_pkg::FN_LOAD_X: r_x        <= i_cmd.ld_val;
                    smkf_pkg::FN_LOAD_P: r_p[w_col] <= i_cmd.ld_val;
                    default:             r_u        <= i_cmd.ld_val;
                endcase
            end
            if (i_cmd.go) begin
                r_xm  <= smkf_pkg::mag(w_opa);
                r_ym  <= smkf_pkg::mag(w_opb);
                r_neg <= w_opa[DW-1] ^ w_opb[DW-1];
                r_clr <= i_cmd.clr;
                r_sum <= '0;
                r_ph  <= 3'd1;
            end else if (r_ph == 3'd5) begin
                r_acc <= smkf_pkg::sadd(r_clr ? '0 : r_acc, w_prod);
                r_ph  <= 3'd0;
            end else if (r_ph != 3'd0) begin
                r_sum <= r_sum + w_add;
                r_ph  <= r_ph + 3'd1;
            end
            case (i_cmd.wb)
                smkf_pkg::WB_XP_U: r_xp          <= smkf_pkg::sadd(r_acc, r_u);
                smkf_pkg::WB_M:    r_m[i_cmd.j]  <= r_acc;
                smkf_pkg::WB_PP:   r_pp[i_cmd.j] <= smkf_pkg::sadd(r_acc, r_q[i_cmd.j]);
                smkf_pkg::WB_PC:   r_pc          <= r_acc;
                smkf_pkg::WB_K:    r_k           <= r_acc;
                smkf_pkg::WB_X:    r_x           <= smkf_pkg::sadd(r_xp, r_acc);
                smkf_pkg::WB_P:    r_p[i_cmd.j]  <= smkf_pkg::ssub(r_pp[i_cmd.j], r_acc);
                default: ;
            endcase
        end
    end

    // running sum handed down the row every cycle, in cell order
    always_ff @(posedge i_clk) begin
        r_chain <= smkf_pkg::sadd(i_chain, r_acc);
    end
    assign o_chain = r_chain;

endmodule

FILE: src/scalar_measurement_kalman_filter.sv
// Scalar-measurement Kalman filter top level: sequencer, cell row, reciprocal.
// Depends on smkf_pkg, smkf_cell and smkf_recip.
//
// Load transfers (tuser 0..5) write one entry of A, Q, C, x, P or u. A step
// transfer (tuser 6) carries measurement y; the block then runs predict, gain
// and correct on a row of N cells, cell i holding row i of every matrix. Each
// phase issues one operand at a time, broadcast to all cells except in the S
// and innovation phases, which use each cell's own C; all cells multiply in
// parallel on a 4-pass 32x32 Q32.32 multiplier. A step makes 3N^2+3N+4
// issues, plus two sum-chain passes, a bit-serial reciprocal and N+N^2 result
// transfers: N state elements (tuser 0), then N*N covariance entries in
// row-major order (tuser 1), tlast on the final one. Input tready is low while
// a step is in progress. R is written through i_cfg_we/i_cfg_wdata only while
// idle, a rule for the user that the block does not enforce; it resets to 1.0.
module scalar_measurement_kalman_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [62:0] i_cfg_wdata,      // meas_noise
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,     // row[1:0], col[3:2], value[67:4], zero
    input  logic [2:0]  s_axis_tuser,     // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,     // row_res[1:0], col_res[3:2], value_res[67:4]
    output logic        m_axis_tuser,     // kind
    output logic        m_axis_tlast      // last
);
    localparam int N  = smkf_pkg::N;
    localparam int IW = smkf_pkg::IW;
    localparam int DW = smkf_pkg::DW;
    localparam logic [IW-1:0] LAST = IW'(N - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_WAIT, S_STEP, S_CHAIN, S_DIV, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        P_XP, P_M, P_PP, P_PC, P_S, P_K, P_IN, P_X, P_KC, P_P
    } t_phase;

    t_state  r_state;
    t_phase  r_phase;
    logic [IW-1:0] r_j, r_q;
    logic [2:0]    r_cnt;
    logic [62:0]   r_meas_noise;
    logic signed [DW-1:0] r_y, r_rec, r_innov;
    logic          r_kind;

    logic          r_out_valid, r_out_kind, r_out_last;
    logic [1:0]    r_out_row, r_out_col;
    logic signed [DW-1:0] r_out_value;

    smkf_pkg::t_cmd w_cmd;
    logic [IW-1:0]  w_rd_cell;
    logic signed [DW-1:0] w_rd [N];
    logic signed [DW-1:0] w_chain [N+1];
    logic signed [DW-1:0] w_sel;
    logic          w_in_acc, w_inner, w_outer, w_inner_done, w_outer_done;
    logic          w_out_load, w_div_start, w_div_done;
    logic signed [DW-1:0] w_rec, w_s;
    smkf_pkg::t_wb w_wb;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // loop shape of each phase: outer over j, inner over q
    always_comb begin
        w_inner = (r_phase == P_XP) || (r_phase == P_M) || (r_phase == P_PP) ||
                  (r_phase == P_PC) || (r_phase == P_P);
        w_outer = (r_phase == P_M) || (r_phase == P_PP) || (r_phase == P_KC) ||
                  (r_phase == P_P);
        w_inner_done = !w_inner || (r_q == LAST);
        w_outer_done = !w_outer || (r_j == LAST);
        unique case (r_phase)
            P_XP:    w_wb = smkf_pkg::WB_XP_U;
            P_M:     w_wb = smkf_pkg::WB_M;
            P_PP:    w_wb = smkf_pkg::WB_PP;
            P_PC:    w_wb = smkf_pkg::WB_PC;
            P_K:     w_wb = smkf_pkg::WB_K;
            P_X:     w_wb = smkf_pkg::WB_X;
            P_KC:    w_wb = smkf_pkg::WB_M;
            P_P:     w_wb = smkf_pkg::WB_P;
            default: w_wb = smkf_pkg::WB_NONE;
        endcase
    end

    // command to the cell row
    always_comb begin
        w_cmd         = '0;
        w_cmd.ld_en   = w_in_acc && (s_axis_tuser < smkf_pkg::FN_STEP);
        w_cmd.ld_func = s_axis_tuser;
        w_cmd.ld_row  = s_axis_tdata[1:0];
        w_cmd.ld_col  = s_axis_tdata[3:2];
        w_cmd.ld_val  = $signed(s_axis_tdata[67:4]);
        w_cmd.go      = (r_state == S_MAC);
        w_cmd.clr     = (r_q == '0);
        w_cmd.q       = r_q;
        w_cmd.j       = r_j;
        w_cmd.bsel    = smkf_pkg::B_BCAST;
        w_cmd.asel    = smkf_pkg::A_A;
        w_cmd.rd_src  = smkf_pkg::RD_X;
        w_cmd.rd_idx  = '0;
        w_rd_cell     = r_q;
        w_cmd.wb      = (r_state == S_STEP && w_inner_done) ? w_wb : smkf_pkg::WB_NONE;
        unique case (r_phase)
            P_XP: begin
                w_cmd.asel = smkf_pkg::A_A;
            end
            P_M: begin
                w_cmd.asel = smkf_pkg::A_A;  w_cmd.rd_src = smkf_pkg::RD_P;
                w_cmd.rd_idx = r_j;
            end
            P_PP: begin
                w_cmd.asel = smkf_pkg::A_M;  w_cmd.rd_src = smkf_pkg::RD_A;
                w_cmd.rd_idx = r_q;          w_rd_cell = r_j;
            end
            P_PC: begin
                w_cmd.asel = smkf_pkg::A_PP; w_cmd.rd_src = smkf_pkg::RD_C;
            end
            P_S: begin
                w_cmd.asel = smkf_pkg::A_PC; w_cmd.bsel = smkf_pkg::B_C;
            end
            P_K: begin
                w_cmd.asel = smkf_pkg::A_PC;
            end
            P_IN: begin
                w_cmd.asel = smkf_pkg::A_XP; w_cmd.bsel = smkf_pkg::B_C;
            end
            P_X: begin
                w_cmd.asel = smkf_pkg::A_K;
            end
            P_KC: begin
                w_cmd.asel = smkf_pkg::A_K;  w_cmd.rd_src = smkf_pkg::RD_C;
                w_rd_cell = r_j;
            end
            default: begin
                w_cmd.asel = smkf_pkg::A_M;  w_cmd.rd_src = smkf_pkg::RD_PP;
                w_cmd.rd_idx = r_j;
            end
        endcase
        // result readout: x by element, then P row by row
        if (r_state == S_OUT) begin
            w_rd_cell     = r_j;
            w_cmd.rd_src  = r_kind ? smkf_pkg::RD_P : smkf_pkg::RD_X;
            w_cmd.rd_idx  = r_q;
        end
        w_sel = w_rd[w_rd_cell];
        if (r_phase == P_K)      w_cmd.bcast = r_rec;
        else if (r_phase == P_X) w_cmd.bcast = r_innov;
        else                     w_cmd.bcast = w_sel;
    end

    assign w_chain[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        smkf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IW'(g)),
            .i_cmd   (w_cmd),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_rd    (w_rd[g])
        );
    end

    assign w_s         = smkf_pkg::sadd($signed({1'b0, r_meas_noise}), w_chain[N]);
    assign w_div_start = (r_state == S_CHAIN) && (r_cnt == '0) && (r_phase == P_S);

    smkf_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_s     (w_s),
        .o_done  (w_div_done),
        .o_rec   (w_rec)
    );

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= P_XP;
            r_j          <= '0;
            r_q          <= '0;
            r_cnt        <= '0;
            r_kind       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_meas_noise <= smkf_pkg::R_RESET;
        end else begin
            if (i_cfg_we) r_meas_noise <= i_cfg_wdata;
            // output register drains unless a new result replaces it
            if (r_out_valid && m_axis_tready && !w_out_load) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && s_axis_tuser == smkf_pkg::FN_STEP) begin
                        r_y     <= $signed(s_axis_tdata[67:4]);
                        r_phase <= P_XP;
                        r_j     <= '0;
                        r_q     <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_cnt   <= 3'd4;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_cnt <= r_cnt - 3'd1;
                    if (r_cnt == '0) r_state <= S_STEP;
                end
                S_STEP: begin
                    if (!w_inner_done) begin
                        r_q     <= r_q + IW'(1);
                        r_state <= S_MAC;
                    end else if (r_phase == P_S || r_phase == P_IN) begin
                        r_cnt   <= 3'(N);
                        r_state <= S_CHAIN;
                    end else if (!w_outer_done) begin
                        r_j     <= r_j + IW'(1);
                        r_q     <= '0;
                        r_state <= S_MAC;
                    end else begin
                        r_j <= '0;
                        r_q <= '0;
                        unique case (r_phase)
                            P_XP:    begin r_phase <= P_M;  r_state <= S_MAC; end
                            P_M:     begin r_phase <= P_PP; r_state <= S_MAC; end
                            P_PP:    begin r_phase <= P_PC; r_state <= S_MAC; end
                            P_PC:    begin r_phase <= P_S;  r_state <= S_MAC; end
                            P_K:     begin r_phase <= P_IN; r_state <= S_MAC; end
                            P_X:     begin r_phase <= P_KC; r_state <= S_MAC; end
                            P_KC:    begin r_phase <= P_P;  r_state <= S_MAC; end
                            default: begin
                                r_kind  <= 1'b0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_CHAIN: begin
                    r_cnt <= r_cnt - 3'd1;
                    if (r_cnt == '0) begin
                        if (r_phase == P_S) begin
                            r_state <= S_DIV;
                        end else begin
                            r_innov <= smkf_pkg::ssub(r_y, w_chain[N]);
                            r_phase <= P_X;
                            r_state <= S_MAC;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_rec   <= w_rec;
                        r_phase <= P_K;
                        r_state <= S_MAC;
                    end
                end
                default: begin
                    if (w_out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_kind;
                        r_out_row   <= 2'(r_j);
                        r_out_col   <= r_kind ? 2'(r_q) : 2'b00;
                        r_out_value <= w_sel;
                        r_out_last  <= r_kind && (r_j == LAST) && (r_q == LAST);
                        if (!r_kind) begin
                            if (r_j == LAST) begin
                                r_kind <= 1'b1;
                                r_j    <= '0;
                                r_q    <= '0;
                            end else begin
                                r_j <= r_j + IW'(1);
                            end
                        end else if (r_q != LAST) begin
                            r_q <= r_q + IW'(1);
                        end else begin
                            r_q <= '0;
                            if (r_j == LAST) begin
                                r_j     <= '0;
                                r_state <= S_IDLE;
                            end else begin
                                r_j <= r_j + IW'(1);
                            end
                        end
                    end
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_value, r_out_col, r_out_row};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // reciprocal finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("reciprocal done outside its wait state");

    // a step ends on a covariance entry
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("last flag on a state element");

    // nothing follows the final result of a step right away
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tready |=> !m_axis_tvalid)
        else $error("result issued right after the final one");
`endif

endmodule
